// ===== sv/srlv_pkg.sv =====
// shared types, constants and helpers of the sensor record line validator
`default_nettype none

package srlv_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned ACC_W   = 14;
  localparam int unsigned FLD_W   = 7;
  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned SEP_W   = 3;

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_SEMI    = 8'h3B;

  localparam logic [POS_W-1:0] POS_YEAR_SEP    = 5'd4;
  localparam logic [POS_W-1:0] POS_MONTH_TENS  = 5'd5;
  localparam logic [POS_W-1:0] POS_MONTH_ONES  = 5'd6;
  localparam logic [POS_W-1:0] POS_MONTH_SEP   = 5'd7;
  localparam logic [POS_W-1:0] POS_DAY_SPACE   = 5'd8;
  localparam logic [POS_W-1:0] POS_DAY_SEP     = 5'd10;
  localparam logic [POS_W-1:0] POS_HOUR_SPACE  = 5'd11;
  localparam logic [POS_W-1:0] POS_HOUR_SEP    = 5'd13;
  localparam logic [POS_W-1:0] POS_MINUTE_SPACE = 5'd14;
  localparam logic [POS_W-1:0] POS_MINUTE_SEP  = 5'd16;
  localparam logic [POS_W-1:0] POS_TEMP_SIGN   = 5'd17;
  localparam logic [POS_W-1:0] POS_TEMP_DIGIT  = 5'd18;
  localparam logic [POS_W-1:0] POS_LAST        = 5'd20;
  localparam logic [POS_W-1:0] POS_SAT         = 5'd31;

  localparam logic [ACC_W-1:0] YEAR_MIN   = 14'd1900;
  localparam logic [ACC_W-1:0] YEAR_MAX   = 14'd2100;
  localparam logic [ACC_W-1:0] MONTH_MAX  = 14'd12;
  localparam logic [ACC_W-1:0] HOUR_MAX   = 14'd23;
  localparam logic [ACC_W-1:0] MINUTE_MAX = 14'd59;
  localparam logic [ACC_W-1:0] TEMP_MAX   = 14'd99;
  localparam logic [ACC_W-1:0] ACC_TEN    = 14'd10;

  localparam logic [SEP_W-1:0] SEP_FULL = 3'd5;
  localparam logic [SEP_W-1:0] SEP_SAT  = 3'd7;

  localparam logic [MONTH_W-1:0] MONTH_RESET = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_TEN   = 4'd10;

  typedef enum logic [1:0] {
    STATUS_VALID     = 2'd0,
    STATUS_MALFORMED = 2'd1,
    STATUS_SKIPPED   = 2'd2
  } status_e;

  typedef struct packed {
    status_e            status;
    logic [YEAR_W-1:0]  year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic signed [7:0]  temperature;
  } rec_t;

  function automatic logic [4:0] month_length(input logic [FLD_W-1:0] month,
                                              input logic leap);
    logic [4:0] len;
    len = 5'd0;
    unique case (month)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                     len = 5'd30;
      7'd2:    len = leap ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== sv/srlv_if.sv =====
// item channel interfaces for characters in and records out
`default_nettype none

interface srlv_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

interface srlv_rec_if;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [11:0]       rec_year;
  logic [3:0]        rec_month;
  logic [4:0]        rec_day;
  logic [4:0]        rec_hour;
  logic [5:0]        rec_minute;
  logic signed [7:0] rec_temperature;

  modport source (output valid, output status, output rec_year, output rec_month,
                  output rec_day, output rec_hour, output rec_minute,
                  output rec_temperature, input ready);
  modport sink   (input valid, input status, input rec_year, input rec_month,
                  input rec_day, input rec_hour, input rec_minute,
                  input rec_temperature, output ready);
endinterface

`default_nettype wire

// ===== sv/srlv_parse.sv =====
// per-line parse state, field checks and record forming for one character
`default_nettype none

module srlv_parse (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire logic [srlv_pkg::CHAR_W-1:0]   char_i,
  input  wire logic [srlv_pkg::MONTH_W-1:0]  target_month_i,
  output logic                               done_o,
  output srlv_pkg::rec_t                     rec_o
);
  import srlv_pkg::*;

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic              neg_q, neg_d;
  logic [SEP_W-1:0]  sep_q, sep_d;
  logic              err_q, err_d;
  logic              oms_q, oms_d;
  logic              mfo_q, mfo_d;
  logic [CHAR_W-1:0] p5_q, p5_d;
  logic              tc_q, tc_d;
  logic              pend_q, pend_d;
  logic [ACC_W-1:0]  year_q, year_d;
  logic [FLD_W-1:0]  month_q, month_d;
  logic [FLD_W-1:0]  day_q, day_d;
  logic [FLD_W-1:0]  hour_q, hour_d;
  logic [FLD_W-1:0]  minute_q, minute_d;
  logic [YEAR_W-1:0] rem_q, rem_d;

  logic              is_nl;
  logic              is_digit;
  logic [3:0]        dval;
  logic [ACC_W-1:0]  acc_mac;
  logic              is_sep;
  logic              space_ok;
  logic [MONTH_W-1:0] ones_val;
  logic [CHAR_W-1:0] tens_char;
  logic [CHAR_W-1:0] ones_char;
  logic [4:0]        mlen;
  logic              skipped;
  logic              malformed;

  assign is_nl    = (char_i == CHAR_NEWLINE);
  assign is_digit = (char_i >= CHAR_ZERO) && (char_i <= CHAR_NINE);
  assign dval     = 4'(char_i - CHAR_ZERO);
  assign acc_mac  = ACC_W'(acc_q * ACC_TEN) + ACC_W'(dval);
  assign is_sep   = (pos_q == POS_YEAR_SEP) || (pos_q == POS_MONTH_SEP) ||
                    (pos_q == POS_DAY_SEP) || (pos_q == POS_HOUR_SEP) ||
                    (pos_q == POS_MINUTE_SEP);
  assign space_ok = (char_i == CHAR_SPACE) &&
                    ((pos_q == POS_MONTH_TENS) || (pos_q == POS_DAY_SPACE) ||
                     (pos_q == POS_HOUR_SPACE) || (pos_q == POS_MINUTE_SPACE));

  // month selection digits
  assign ones_val  = (target_month_i >= MONTH_TEN) ? 4'(target_month_i - MONTH_TEN)
                                                    : target_month_i;
  assign tens_char = (target_month_i >= MONTH_TEN) ? 8'(CHAR_ZERO + 8'd1) : CHAR_ZERO;
  assign ones_char = 8'(CHAR_ZERO + {4'b0, ones_val});

  assign mlen      = month_length(month_q, (year_q[1:0] == 2'b00));
  assign skipped   = (pos_q < POS_MONTH_SEP) || !mfo_q || oms_q;
  assign malformed = err_q || (sep_q != SEP_FULL) || !tc_q || (acc_q > TEMP_MAX);

  always_comb begin
    pos_d    = pos_q;
    acc_d    = acc_q;
    neg_d    = neg_q;
    sep_d    = sep_q;
    err_d    = err_q;
    oms_d    = oms_q;
    mfo_d    = mfo_q;
    p5_d     = p5_q;
    tc_d     = tc_q;
    pend_d   = pend_q;
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    rem_d    = rem_q;
    rec_o    = '0;
    done_o   = step_i && is_nl;

    priority if (skipped) begin
      rec_o.status = STATUS_SKIPPED;
    end else if (malformed) begin
      rec_o.status = STATUS_MALFORMED;
    end else begin
      rec_o.status      = STATUS_VALID;
      rec_o.year        = year_q[YEAR_W-1:0];
      rec_o.month       = month_q[3:0];
      rec_o.day         = day_q[4:0];
      rec_o.hour        = hour_q[4:0];
      rec_o.minute      = minute_q[5:0];
      rec_o.temperature = neg_q ? 8'(8'd0 - acc_q[7:0]) : acc_q[7:0];
    end

    if (step_i) begin
      if (is_nl) begin
        // year memory takes the first matching line's year
        if ((pos_q >= POS_MONTH_SEP) && mfo_q && pend_q) begin
          rem_d = year_q[YEAR_W-1:0];
        end
        pos_d    = '0;
        acc_d    = '0;
        neg_d    = 1'b0;
        sep_d    = '0;
        err_d    = 1'b0;
        oms_d    = 1'b0;
        mfo_d    = 1'b0;
        p5_d     = '0;
        tc_d     = 1'b0;
        pend_d   = 1'b0;
        year_d   = '0;
        month_d  = '0;
        day_d    = '0;
        hour_d   = '0;
        minute_d = '0;
      end else begin
        priority if (is_sep) begin
          acc_d = '0;
          if (char_i != CHAR_SEMI) begin
            err_d = 1'b1;
          end else begin
            if (sep_q < SEP_SAT) begin
              sep_d = 3'(sep_q + 3'd1);
            end
            priority case (pos_q)
              POS_YEAR_SEP: begin
                year_d = acc_q;
                if ((rem_q == '0) && (acc_q >= YEAR_MIN) && (acc_q <= YEAR_MAX)) begin
                  pend_d = !err_q;
                end else if (!((rem_q != '0) && (acc_q == ACC_W'(rem_q)))) begin
                  err_d = 1'b1;
                end
              end
              POS_MONTH_SEP: begin
                month_d = acc_q[FLD_W-1:0];
                if (acc_q != ACC_W'(target_month_i)) begin
                  if ((acc_q >= 14'd1) && (acc_q <= MONTH_MAX) && !err_q) begin
                    oms_d = 1'b1;
                  end else begin
                    err_d = 1'b1;
                  end
                end
              end
              POS_DAY_SEP: begin
                day_d = acc_q[FLD_W-1:0];
                if ((acc_q == '0) || (acc_q > ACC_W'(mlen))) begin
                  err_d = 1'b1;
                end
              end
              POS_HOUR_SEP: begin
                hour_d = acc_q[FLD_W-1:0];
                if (acc_q > HOUR_MAX) begin
                  err_d = 1'b1;
                end
              end
              default: begin
                minute_d = acc_q[FLD_W-1:0];
                if (acc_q > MINUTE_MAX) begin
                  err_d = 1'b1;
                end
              end
            endcase
          end
        end else if (pos_q == POS_TEMP_SIGN) begin
          if (char_i == CHAR_MINUS) begin
            neg_d = 1'b1;
          end else if (is_digit) begin
            acc_d = ACC_W'(dval);
            tc_d  = 1'b1;
          end else if (char_i != CHAR_SPACE) begin
            err_d = 1'b1;
          end
        end else begin
          if (pos_q > POS_LAST) begin
            err_d = 1'b1;
          end else if (is_digit) begin
            acc_d = acc_mac;
            if (pos_q >= POS_TEMP_DIGIT) begin
              tc_d = 1'b1;
            end
          end else if (!space_ok) begin
            err_d = 1'b1;
          end
          if (pos_q == POS_MONTH_TENS) begin
            p5_d = char_i;
          end
          if (pos_q == POS_MONTH_ONES) begin
            mfo_d = ((p5_q == tens_char) || (p5_q == CHAR_SPACE)) && (char_i == ones_char);
          end
        end
        if (pos_q < POS_SAT) begin
          pos_d = 5'(pos_q + 5'd1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      acc_q    <= '0;
      neg_q    <= 1'b0;
      sep_q    <= '0;
      err_q    <= 1'b0;
      oms_q    <= 1'b0;
      mfo_q    <= 1'b0;
      p5_q     <= '0;
      tc_q     <= 1'b0;
      pend_q   <= 1'b0;
      year_q   <= '0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      rem_q    <= '0;
    end else begin
      pos_q    <= pos_d;
      acc_q    <= acc_d;
      neg_q    <= neg_d;
      sep_q    <= sep_d;
      err_q    <= err_d;
      oms_q    <= oms_d;
      mfo_q    <= mfo_d;
      p5_q     <= p5_d;
      tc_q     <= tc_d;
      pend_q   <= pend_d;
      year_q   <= year_d;
      month_q  <= month_d;
      day_q    <= day_d;
      hour_q   <= hour_d;
      minute_q <= minute_d;
      rem_q    <= rem_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sensor_record_line_validator.sv =====
// top level: input register, line parser, record register, month register
//
// channel   dir  payload                                   accepted when
// char_i    in   character[7:0]                            valid && ready
// rec_o     out  status, rec_year..rec_minute, rec_temp    valid && ready
// cfg       in   cfg_wdata_i[3:0] target month             cfg_we_i
//
// one character per cycle unless a newline waits; a record enters the record
// register at the parse step of its newline, after the input register
// the parse step runs on the character held in the input register
// a newline waits in the input register while the record register is full and
// not taken, which holds char_i.ready low; other characters never wait
// reset clears all line state, the year memory and sets target month to 1
`default_nettype none

module sensor_record_line_validator (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [srlv_pkg::MONTH_W-1:0] cfg_wdata_i,
  srlv_char_if.sink                         char_i,
  srlv_rec_if.source                        rec_o
);
  import srlv_pkg::*;

  logic [MONTH_W-1:0] target_month_q;
  logic               in_valid_q;
  logic [CHAR_W-1:0]  char_q;
  logic               out_valid_q;
  rec_t               rec_q;

  logic               fire;
  logic               done;
  rec_t               rec_next;

  assign fire = in_valid_q &&
                ((char_q != CHAR_NEWLINE) || !out_valid_q || rec_o.ready);
  assign char_i.ready = !in_valid_q || fire;

  srlv_parse u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (fire),
    .char_i         (char_q),
    .target_month_i (target_month_q),
    .done_o         (done),
    .rec_o          (rec_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_month_q <= MONTH_RESET;
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        target_month_q <= cfg_wdata_i;
      end
      if (char_i.ready) begin
        in_valid_q <= char_i.valid;
      end
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (rec_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.valid && char_i.ready) begin
      char_q <= char_i.character;
    end
    if (done) begin
      rec_q <= rec_next;
    end
  end

  assign rec_o.valid           = out_valid_q;
  assign rec_o.status          = rec_q.status;
  assign rec_o.rec_year        = rec_q.year;
  assign rec_o.rec_month       = rec_q.month;
  assign rec_o.rec_day         = rec_q.day;
  assign rec_o.rec_hour        = rec_q.hour;
  assign rec_o.rec_minute      = rec_q.minute;
  assign rec_o.rec_temperature = rec_q.temperature;

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rec_o.ready) |-> !done)
    else $error("record register overwritten while full");

  a_valid_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rec_o.valid && (rec_o.status == STATUS_VALID)) |->
      (rec_o.rec_month == target_month_q))
    else $error("valid record of an unselected month");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rec_o.valid && (rec_o.status != STATUS_VALID)) |->
      ((rec_o.rec_year == '0) && (rec_o.rec_temperature == '0)))
    else $error("fields not cleared on a rejected line");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !fire) |=> (in_valid_q && $stable(char_q)))
    else $error("stalled character lost from input register");
`endif

endmodule

`default_nettype wire
